>>> design/gdm_pkg.sv
// Shared constants, types and the CORDIC angle table for the galvo DAC mapper.
`default_nettype none

package gdm_pkg;

  // Field and register widths
  localparam int COORD_W   = 24;
  localparam int CODE_W    = 12;
  localparam int ST_W      = 3;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  // CORDIC datapath
  localparam int CORDIC_STAGES = 16;
  localparam int STG_W         = 5;
  localparam int CX_W          = 42;
  localparam int ANG_W         = 25;
  localparam int A_W           = 16;

  // Voltage and code datapath
  localparam int DAC_MAX_CODE = 4095;
  localparam int PR_W         = 33;
  localparam int P_W          = 44;
  localparam int N_W          = 58;
  localparam int M_W          = 28;
  localparam int DIV_STAGES   = 12;
  localparam int DIV_IDX_W    = 4;
  localparam int VOLT_LAT     = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_MV  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VPD     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MV  = 3'd7;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_BOX   = 3'd1,
    ST_Z     = 3'd2,
    ST_ANGLE = 3'd3,
    ST_CONV  = 3'd4,
    ST_DAC   = 3'd5
  } status_t;

  // One beat moving down the CORDIC chain, both channels side by side
  typedef struct packed {
    logic                    vld;
    status_t                 st;
    logic signed [CX_W-1:0]  x_den;
    logic signed [CX_W-1:0]  x_num;
    logic signed [ANG_W-1:0] x_ang;
    logic signed [CX_W-1:0]  y_den;
    logic signed [CX_W-1:0]  y_num;
    logic signed [ANG_W-1:0] y_ang;
  } cordic_beat_t;

  // One beat moving down the divider chain
  typedef struct packed {
    logic              vld;
    status_t           st;
    logic [M_W-1:0]    x_rem;
    logic [CODE_W-1:0] x_quo;
    logic [M_W-1:0]    y_rem;
    logic [CODE_W-1:0] y_quo;
  } div_beat_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STG_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      5'd0:  v = 25'sd2949120;
      5'd1:  v = 25'sd1740967;
      5'd2:  v = 25'sd919879;
      5'd3:  v = 25'sd466945;
      5'd4:  v = 25'sd234379;
      5'd5:  v = 25'sd117304;
      5'd6:  v = 25'sd58666;
      5'd7:  v = 25'sd29335;
      5'd8:  v = 25'sd14668;
      5'd9:  v = 25'sd7334;
      5'd10: v = 25'sd3667;
      5'd11: v = 25'sd1833;
      5'd12: v = 25'sd917;
      5'd13: v = 25'sd458;
      5'd14: v = 25'sd229;
      5'd15: v = 25'sd115;
      5'd16: v = 25'sd57;
      5'd17: v = 25'sd29;
      5'd18: v = 25'sd14;
      5'd19: v = 25'sd7;
      5'd20: v = 25'sd4;
      5'd21: v = 25'sd2;
      5'd22: v = 25'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> design/gdm_if.sv
// Valid/ready channel interfaces for target points and DAC results.
`default_nettype none

interface gdm_in_if;
  import gdm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_pos;
  logic signed [COORD_W-1:0] y_pos;
  logic signed [COORD_W-1:0] z_pos;
  modport source (output valid, x_pos, y_pos, z_pos, input ready);
  modport sink   (input valid, x_pos, y_pos, z_pos, output ready);
endinterface

interface gdm_out_if;
  import gdm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] dac_x_code;
  logic [CODE_W-1:0] dac_y_code;
  logic [ST_W-1:0]   status;
  modport source (output valid, dac_x_code, dac_y_code, status, input ready);
  modport sink   (input valid, dac_x_code, dac_y_code, status, output ready);
endinterface

`default_nettype wire

>>> design/point_to_galvo_dac_mapper.sv
// Throughput: one point per cycle; the whole pipeline advances together and
// holds while a result waits in the output register.
// Stages: input check, 16 CORDIC cells, angle rounding, 5 voltage stages,
// 12 divider cells, output register. Reset is synchronous and active low; it
// clears all valid flags and loads the register reset values; no clearing pass.
`default_nettype none

module point_to_galvo_dac_mapper (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  gdm_in_if.sink                                 in_ch,
  gdm_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [gdm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gdm_pkg::CFG_W-1:0]         cfg_data
);
  import gdm_pkg::*;

  // Configuration registers
  logic [47:0] box_x_r, box_y_r, box_z_r;
  logic [31:0] tilt_x_r, tilt_y_r;
  logic [15:0] ref_mv_r, vpd_r, max_mv_r;

  logic adv;

  cordic_beat_t c0_r, c0_nxt;
  cordic_beat_t cchain [CORDIC_STAGES+1];

  logic                  p1_vld_r;
  status_t               p1_st_r;
  status_t               p1_st_nxt;
  logic signed [A_W-1:0] ax_r, ay_r;
  logic signed [A_W-1:0] ax_nxt, ay_nxt;

  logic    vld_pipe_r [VOLT_LAT];
  status_t st_pipe_r  [VOLT_LAT];

  logic           badx, bady;
  logic [M_W-1:0] mvalx, mvaly;

  div_beat_t d0_nxt;
  div_beat_t dchain [DIV_STAGES+1];

  logic              out_vld_r;
  logic [CODE_W-1:0] out_x_r, out_y_r;
  status_t           out_st_r;

  // Round a CORDIC angle to 1/128 degree, half away from zero.
  function automatic logic signed [A_W-1:0] round_ang(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] mag;
    mag = a[ANG_W-1] ? -a : a;
    mag = (mag + ANG_W'(256)) >>> 9;
    return a[ANG_W-1] ? A_W'(-mag) : A_W'(mag);
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r  <= '0;
      box_y_r  <= '0;
      box_z_r  <= '0;
      tilt_x_r <= '0;
      tilt_y_r <= '0;
      ref_mv_r <= 16'd5000;
      vpd_r    <= 16'd8192;
      max_mv_r <= 16'd10000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOX_X:  box_x_r  <= cfg_data[47:0];
        CFG_BOX_Y:  box_y_r  <= cfg_data[47:0];
        CFG_BOX_Z:  box_z_r  <= cfg_data[47:0];
        CFG_TILT_X: tilt_x_r <= cfg_data[31:0];
        CFG_TILT_Y: tilt_y_r <= cfg_data[31:0];
        CFG_REF_MV: ref_mv_r <= cfg_data[15:0];
        CFG_VPD:    vpd_r    <= cfg_data[15:0];
        CFG_MAX_MV: max_mv_r <= cfg_data[15:0];
      endcase
    end
  end

  // The whole pipeline moves when the output register can take a beat.
  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Input stage: box and depth checks, CORDIC start vectors.
  always_comb begin
    c0_nxt     = '0;
    c0_nxt.vld = in_ch.valid;
    if ((in_ch.x_pos < $signed(box_x_r[23:0])) || (in_ch.x_pos > $signed(box_x_r[47:24])) ||
        (in_ch.y_pos < $signed(box_y_r[23:0])) || (in_ch.y_pos > $signed(box_y_r[47:24])) ||
        (in_ch.z_pos < $signed(box_z_r[23:0])) || (in_ch.z_pos > $signed(box_z_r[47:24]))) begin
      c0_nxt.st = ST_BOX;
    end else if (in_ch.z_pos <= 0) begin
      c0_nxt.st = ST_Z;
    end else begin
      c0_nxt.st = ST_OK;
    end
    c0_nxt.x_den = CX_W'($signed({in_ch.z_pos, 16'b0}));
    c0_nxt.x_num = CX_W'($signed({in_ch.x_pos, 16'b0}));
    c0_nxt.y_den = CX_W'($signed({in_ch.z_pos, 16'b0}));
    c0_nxt.y_num = CX_W'($signed({in_ch.y_pos, 16'b0}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r <= '0;
    end else if (adv) begin
      c0_r <= c0_nxt;
    end
  end

  // CORDIC cell chain
  assign cchain[0] = c0_r;
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    gdm_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .stage_idx (STG_W'(g)),
      .d_in      (cchain[g]),
      .d_out     (cchain[g+1])
    );
  end

  // Angle rounding, angle limits and conversion checks.
  always_comb begin
    ax_nxt = round_ang(cchain[CORDIC_STAGES].x_ang);
    ay_nxt = round_ang(cchain[CORDIC_STAGES].y_ang);
    if (cchain[CORDIC_STAGES].st != ST_OK) begin
      p1_st_nxt = cchain[CORDIC_STAGES].st;
    end else if ((ax_nxt < $signed(tilt_x_r[15:0])) || (ax_nxt > $signed(tilt_x_r[31:16])) ||
                 (ay_nxt < $signed(tilt_y_r[15:0])) || (ay_nxt > $signed(tilt_y_r[31:16]))) begin
      p1_st_nxt = ST_ANGLE;
    end else if ((vpd_r == 16'd0) || (ref_mv_r == 16'd0)) begin
      p1_st_nxt = ST_CONV;
    end else begin
      p1_st_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p1_st_r  <= ST_OK;
    end else if (adv) begin
      p1_vld_r <= cchain[CORDIC_STAGES].vld;
      p1_st_r  <= p1_st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
    end
  end

  // Voltage datapath, one per channel.
  gdm_volt u_volt_x (
    .clk    (clk),
    .en     (adv),
    .ang    (ax_r),
    .scale  (vpd_r),
    .ref_mv (ref_mv_r),
    .max_mv (max_mv_r),
    .bad    (badx),
    .mval   (mvalx)
  );

  gdm_volt u_volt_y (
    .clk    (clk),
    .en     (adv),
    .ang    (ay_r),
    .scale  (vpd_r),
    .ref_mv (ref_mv_r),
    .max_mv (max_mv_r),
    .bad    (bady),
    .mval   (mvaly)
  );

  // Valid and status travel beside the voltage stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOLT_LAT; i++) begin
        vld_pipe_r[i] <= 1'b0;
        st_pipe_r[i]  <= ST_OK;
      end
    end else if (adv) begin
      vld_pipe_r[0] <= p1_vld_r;
      st_pipe_r[0]  <= p1_st_r;
      for (int i = 1; i < VOLT_LAT; i++) begin
        vld_pipe_r[i] <= vld_pipe_r[i-1];
        st_pipe_r[i]  <= st_pipe_r[i-1];
      end
    end
  end

  // Divider chain entry: fold in the voltage and range checks.
  always_comb begin
    d0_nxt       = '0;
    d0_nxt.vld   = vld_pipe_r[VOLT_LAT-1];
    d0_nxt.x_rem = mvalx;
    d0_nxt.y_rem = mvaly;
    if (st_pipe_r[VOLT_LAT-1] != ST_OK) begin
      d0_nxt.st = st_pipe_r[VOLT_LAT-1];
    end else if (badx || bady) begin
      d0_nxt.st = ST_DAC;
    end else begin
      d0_nxt.st = ST_OK;
    end
  end

  assign dchain[0] = d0_nxt;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    gdm_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .bit_idx (DIV_IDX_W'(DIV_STAGES - 1 - g)),
      .ref_mv  (ref_mv_r),
      .d_in    (dchain[g]),
      .d_out   (dchain[g+1])
    );
  end

  // Output register; codes are zero unless the status is ok.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      out_st_r  <= ST_OK;
      out_x_r   <= '0;
      out_y_r   <= '0;
    end else if (adv) begin
      out_vld_r <= dchain[DIV_STAGES].vld;
      out_st_r  <= dchain[DIV_STAGES].st;
      out_x_r   <= (dchain[DIV_STAGES].st == ST_OK) ? dchain[DIV_STAGES].x_quo : '0;
      out_y_r   <= (dchain[DIV_STAGES].st == ST_OK) ? dchain[DIV_STAGES].y_quo : '0;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.dac_x_code = out_x_r;
  assign out_ch.dac_y_code = out_y_r;
  assign out_ch.status     = out_st_r;

endmodule

`default_nettype wire

>>> design/gdm_cordic_cell.sv
// One vectoring CORDIC stage for both the x and y angle channels.
`default_nettype none

module gdm_cordic_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic [gdm_pkg::STG_W-1:0]   stage_idx,
  input  wire gdm_pkg::cordic_beat_t       d_in,
  output gdm_pkg::cordic_beat_t            d_out
);
  import gdm_pkg::*;

  cordic_beat_t beat_r;
  cordic_beat_t beat_nxt;
  logic signed [ANG_W-1:0] step_ang;

  // Rotate toward the axis; the sign of the numerator picks the direction.
  always_comb begin
    step_ang = atan_entry(stage_idx);
    beat_nxt = d_in;
    if (!d_in.x_num[CX_W-1]) begin
      beat_nxt.x_den = d_in.x_den + (d_in.x_num >>> stage_idx);
      beat_nxt.x_num = d_in.x_num - (d_in.x_den >>> stage_idx);
      beat_nxt.x_ang = d_in.x_ang + step_ang;
    end else begin
      beat_nxt.x_den = d_in.x_den - (d_in.x_num >>> stage_idx);
      beat_nxt.x_num = d_in.x_num + (d_in.x_den >>> stage_idx);
      beat_nxt.x_ang = d_in.x_ang - step_ang;
    end
    if (!d_in.y_num[CX_W-1]) begin
      beat_nxt.y_den = d_in.y_den + (d_in.y_num >>> stage_idx);
      beat_nxt.y_num = d_in.y_num - (d_in.y_den >>> stage_idx);
      beat_nxt.y_ang = d_in.y_ang + step_ang;
    end else begin
      beat_nxt.y_den = d_in.y_den - (d_in.y_num >>> stage_idx);
      beat_nxt.y_num = d_in.y_num + (d_in.y_den >>> stage_idx);
      beat_nxt.y_ang = d_in.y_ang - step_ang;
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign d_out = beat_r;

endmodule

`default_nettype wire

>>> design/gdm_volt.sv
// Drive voltage, magnitude check and scaled DAC numerator for one channel.
`default_nettype none

module gdm_volt (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic signed [gdm_pkg::A_W-1:0]   ang,
  input  wire logic [15:0]                      scale,
  input  wire logic [15:0]                      ref_mv,
  input  wire logic [15:0]                      max_mv,
  output logic                                  bad,
  output logic [gdm_pkg::M_W-1:0]               mval
);
  import gdm_pkg::*;

  logic signed [PR_W-1:0] prod_r;
  logic signed [P_W-1:0]  p_r;
  logic signed [P_W-1:0]  t_r;
  logic                   magbad_r;
  logic signed [N_W-1:0]  n_r;
  logic                   magbad2_r;
  logic                   bad_r;
  logic [M_W-1:0]         mval_r;

  logic signed [P_W-1:0]  pabs;
  logic signed [N_W-1:0]  num_full;
  logic signed [N_W-1:0]  mfull;
  logic                   over;

  // Magnitude check and offset by the reference.
  always_comb begin
    pabs = p_r[P_W-1] ? -p_r : p_r;
  end

  // Rounded quotient numerator, scaled down by the power-of-two part of the divisor.
  always_comb begin
    num_full = (n_r <<< 1) + $signed(N_W'({ref_mv, 22'b0}));
    mfull    = num_full >>> 23;
    over     = mfull >= $signed(N_W'({ref_mv, 12'b0}));
  end

  // Five register stages: angle*scale, *1000, check and offset, *DAC_MAX_CODE, numerator.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r    <= PR_W'(ang) * PR_W'($signed({1'b0, scale}));
      p_r       <= P_W'(prod_r) * P_W'(1000);
      magbad_r  <= pabs > $signed(P_W'({max_mv, 21'b0}));
      t_r       <= p_r + $signed(P_W'({ref_mv, 21'b0}));
      n_r       <= N_W'(t_r) * N_W'(DAC_MAX_CODE);
      magbad2_r <= magbad_r;
      bad_r     <= magbad2_r || (num_full <= 0) || over;
      mval_r    <= mfull[M_W-1:0];
    end
  end

  assign bad  = bad_r;
  assign mval = mval_r;

endmodule

`default_nettype wire

>>> design/gdm_div_cell.sv
// One restoring-division step per channel, dividing by the reference voltage.
`default_nettype none

module gdm_div_cell (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire logic [gdm_pkg::DIV_IDX_W-1:0]   bit_idx,
  input  wire logic [15:0]                     ref_mv,
  input  wire gdm_pkg::div_beat_t              d_in,
  output gdm_pkg::div_beat_t                   d_out
);
  import gdm_pkg::*;

  div_beat_t      beat_r;
  div_beat_t      beat_nxt;
  logic [M_W-1:0] dsor;

  // Subtract the shifted divisor where it fits and set the quotient bit.
  always_comb begin
    dsor     = M_W'(ref_mv) << bit_idx;
    beat_nxt = d_in;
    if (d_in.x_rem >= dsor) begin
      beat_nxt.x_rem          = d_in.x_rem - dsor;
      beat_nxt.x_quo[bit_idx] = 1'b1;
    end
    if (d_in.y_rem >= dsor) begin
      beat_nxt.y_rem          = d_in.y_rem - dsor;
      beat_nxt.y_quo[bit_idx] = 1'b1;
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign d_out = beat_r;

endmodule

`default_nettype wire
